FILE: src/sam_pkg.sv
// Shared constants for the sine amplitude modulator: field widths, register indexes, reset values and pi/2.
package sam_pkg;

  localparam int MOD_W   = 16;
  localparam int TIME_W  = 32;
  localparam int FREQ_W  = 24;
  localparam int CFG_W   = 16;
  localparam int OUT_W   = 21;
  localparam int SINE_W  = 16;
  localparam int FRAC_W  = 32;
  localparam int AMP_W   = 33;  // Q27 amplitude, signed
  localparam int PROD_W  = 50;  // Q42 product, signed

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AM_OFFSET     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 2'd2;

  localparam logic [CFG_W-1:0] PARTIAL_RATIO_RESET = 16'd256;
  localparam logic [CFG_W-1:0] AM_OFFSET_RESET     = 16'd4096;
  localparam logic [CFG_W-1:0] MOD_DEPTH_RESET     = 16'd4096;

  // pi/2 in Q30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

endpackage

FILE: src/sine_amplitude_modulator.sv
// Top level: amplitude modulation of a table-driven sine carrier, five-stage pipeline.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  modulator_sample, sample_time,
//                                             note_frequency, last_in_block
//   output    out        out_valid/out_stall  am_sample, last_out
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per cycle unless a stalled output holds the pipeline.
// Stages: phase and gain products, phase wrap and amplitude sum, sine table read,
// carrier product, rounding into the output register.
// rst (synchronous) empties the pipeline and loads the register defaults.
// A stalled valid output holds the whole pipeline; in_stall follows it in the same cycle.
module sine_amplitude_modulator
  import sam_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [MOD_W-1:0]     modulator_sample,
  input  logic        [TIME_W-1:0]    sample_time,
  input  logic        [FREQ_W-1:0]    note_frequency,
  input  logic                        last_in_block,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     am_sample,
  output logic                        last_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int REST_W  = PHASE_BITS - 2;
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SCALE_W = REST_W + DEPTH_W;

  localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_W-1:0]   IDX_MAX = IDX_W'(SINE_TABLE_DEPTH - 1);

  // Configuration registers
  logic        [CFG_W-1:0] partial_ratio;
  logic signed [CFG_W-1:0] am_offset;
  logic signed [CFG_W-1:0] mod_depth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_ratio <= PARTIAL_RATIO_RESET;
      am_offset     <= AM_OFFSET_RESET;
      mod_depth     <= MOD_DEPTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PARTIAL_RATIO: partial_ratio <= cfg_data;
        REG_AM_OFFSET:     am_offset     <= cfg_data;
        REG_MOD_DEPTH:     mod_depth     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Quarter-wave sine table, Q1.15, built at elaboration by a Taylor series in Q30
  logic [SINE_W-1:0] quarter_sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] X  = (64'(2 * k + 1) * PI_HALF_Q30) /
                                 (64'(2) * 64'(SINE_TABLE_DEPTH));
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic signed [63:0] SUM = signed'(X) - signed'(T1) + signed'(T2)
                                       - signed'(T3) + signed'(T4) - signed'(T5);
    localparam logic signed [63:0] RND = (SUM < 0) ? 64'sd0 : ((SUM + 64'sd16384) >>> 15);
    localparam logic signed [63:0] VAL = (RND > 64'sd32767) ? 64'sd32767 : RND;
    assign quarter_sine_rom[k] = VAL[SINE_W-1:0];
  end

  // Pipeline advances unless a finished result is held at the output
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // Stage valids
  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Stage 1: partial ratio times frequency, depth times modulator
  logic        [FRAC_W-1:0] s1_pf;
  logic        [TIME_W-1:0] s1_time;
  logic signed [31:0]       s1_dm;
  logic                     s1_last;

  // Stage 2: phase in cycles, Q27 amplitude
  logic        [FRAC_W-1:0] s2_frac;
  logic signed [AMP_W-1:0]  s2_amp;
  logic                     s2_last;

  // Stage 3: table data and sign
  logic        [SINE_W-1:0] s3_sine;
  logic                     s3_neg;
  logic signed [AMP_W-1:0]  s3_amp;
  logic                     s3_last;

  // Stage 4: Q42 product
  logic signed [PROD_W-1:0] s4_prod;
  logic                     s4_last;

  // Table address from the phase
  logic [PHASE_BITS-1:0] phase;
  logic [1:0]            quadrant;
  logic [REST_W-1:0]     rest;
  logic [SCALE_W-1:0]    scaled;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      rom_addr;

  assign phase    = s2_frac[FRAC_W-1 -: PHASE_BITS];
  assign quadrant = phase[PHASE_BITS-1 -: 2];
  assign rest     = phase[REST_W-1:0];
  assign scaled   = SCALE_W'(rest) * SCALE_W'(DEPTH_C);
  assign idx      = scaled[REST_W +: IDX_W];
  assign rom_addr = quadrant[0] ? (IDX_MAX - idx) : idx;

  // Signed carrier and rounding
  logic signed [SINE_W:0]   sine_s;
  logic signed [PROD_W:0]   rounded;

  assign sine_s  = s3_neg ? -$signed({1'b0, s3_sine}) : $signed({1'b0, s3_sine});
  assign rounded = (PROD_W + 1)'(s4_prod) + (PROD_W + 1)'(64'sd1 <<< 26);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pf   <= FRAC_W'(40'(partial_ratio) * 40'(note_frequency));
      s1_time <= sample_time;
      s1_dm   <= 32'(mod_depth) * 32'(modulator_sample);
      s1_last <= last_in_block;

      s2_frac <= s1_pf * s1_time;
      s2_amp  <= (AMP_W'(am_offset) <<< 15) + AMP_W'(s1_dm);
      s2_last <= s1_last;

      s3_sine <= quarter_sine_rom[rom_addr];
      s3_neg  <= quadrant[1];
      s3_amp  <= s2_amp;
      s3_last <= s2_last;

      s4_prod <= PROD_W'(s3_amp) * PROD_W'(sine_s);
      s4_last <= s3_last;

      // floor((prod + 2^26) / 2^27), low bits
      am_sample <= rounded[27 +: OUT_W];
      last_out  <= s4_last;
    end
  end

endmodule
